// File: rtl/core/rsl_pkg.sv
// Package for the request slot table: word types, codes and defaults.
`timescale 1ns / 1ps
`default_nettype none
package rsl_pkg;

    // Default table depth
    localparam int unsigned NUM_SLOTS_DEF = 8;

    // Configuration register
    localparam logic [3:0] SLOTS_IN_USE_RESET = 4'd8;
    localparam logic       REG_SLOTS_IN_USE   = 1'b0;

    typedef enum logic {
        OP_LOOKUP  = 1'b0,
        OP_RELEASE = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        ST_HIT      = 3'd0,
        ST_ALLOC    = 3'd1,
        ST_FULL     = 3'd2,
        ST_RELEASED = 3'd3,
        ST_REL_MISS = 3'd4
    } status_t;

    // Input word
    typedef struct packed {
        op_t         op;
        logic [6:0]  request_id;
        logic [27:0] remote_id;
        logic [3:0]  group_num;
    } req_word_t;

    // Result word
    typedef struct packed {
        logic [2:0] slot_index;
        status_t    status;
    } rsp_word_t;

    // Key stored in each slot
    typedef struct packed {
        logic [6:0]  request_id;
        logic [27:0] remote_id;
        logic [3:0]  group_num;
    } key_t;

    // Search wave handed from cell to cell; indexes keep the low 3 bits
    typedef struct packed {
        logic       live;
        logic       hit;
        logic [2:0] hit_idx;
        logic       free;
        logic [2:0] free_idx;
    } carry_t;

    // Update broadcast to all cells at the end of a search
    typedef struct packed {
        logic alloc;
        logic release_slot;
    } commit_t;

endpackage
`default_nettype wire

// File: rtl/core/rsl_slot_cell.sv
// One slot of the table: stored key, valid bit and one stage of the search wave.
`timescale 1ns / 1ps
`default_nettype none
module rsl_slot_cell #(
    parameter int unsigned SLOT_NUM = 0
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [3:0]       slots_in_use,
    input  wire rsl_pkg::key_t    key,
    input  wire rsl_pkg::carry_t  carry_in,
    input  wire rsl_pkg::commit_t commit,
    output rsl_pkg::carry_t       carry_out
);
    import rsl_pkg::*;

    localparam logic [2:0] SLOT_LOW = 3'(SLOT_NUM % 8);

    logic    valid_reg;
    key_t    slot_key_reg;
    logic    sel_hit_reg;
    logic    sel_free_reg;
    carry_t  carry_reg;
    carry_t  carry_next;
    logic    active;
    logic    hit_here;
    logic    free_here;

    // Slot takes part only below the configured count
    assign active    = 32'(SLOT_NUM) < 32'(slots_in_use);
    assign hit_here  = active && valid_reg && (slot_key_reg == key);
    assign free_here = active && !valid_reg;

    // Merge this slot into the wave; lower slots win
    always_comb
    begin
        carry_next.live     = carry_in.live;
        carry_next.hit      = carry_in.hit | hit_here;
        carry_next.hit_idx  = carry_in.hit ? carry_in.hit_idx : SLOT_LOW;
        carry_next.free     = carry_in.free | free_here;
        carry_next.free_idx = carry_in.free ? carry_in.free_idx : SLOT_LOW;
    end

    // Wave register and local selection flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            carry_reg    <= '0;
            sel_hit_reg  <= 1'b0;
            sel_free_reg <= 1'b0;
        end
        else
        begin
            carry_reg <= carry_next;
            if (carry_in.live)
            begin
                sel_hit_reg  <= hit_here && !carry_in.hit;
                sel_free_reg <= free_here && !carry_in.free;
            end
        end
    end

    // Valid bit: set on allocate, cleared on release
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (commit.alloc && sel_free_reg)
        begin
            valid_reg <= 1'b1;
        end
        else if (commit.release_slot && sel_hit_reg)
        begin
            valid_reg <= 1'b0;
        end
    end

    // Key storage
    always_ff @(posedge clk)
    begin
        if (commit.alloc && sel_free_reg)
        begin
            slot_key_reg <= key;
        end
    end

    assign carry_out = carry_reg;

endmodule
`default_nettype wire

// File: rtl/core/request_slot_table.sv
// accept registers the word and launch_reg; done comes from the wave register of the last cell.
// A new word is taken only once busy has dropped after done; the search wave walks the
//   chain of slot cells one cell per cycle, then the update is applied.
// done is high for exactly one cycle with rsp_word; the receiver cannot stall.
// Reset: every slot free, slots_in_use = 8, block idle.
`timescale 1ns / 1ps
`default_nettype none
module request_slot_table #(
    parameter int unsigned NUM_SLOTS = rsl_pkg::NUM_SLOTS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    // command channel
    input  wire logic               start,
    input  wire rsl_pkg::req_word_t req_word,
    output logic                    busy,
    output logic                    done,
    output rsl_pkg::rsp_word_t      rsp_word,
    // configuration port
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);
    import rsl_pkg::*;

    logic [3:0]  slots_reg;
    logic        busy_reg;
    logic        busy_next;
    logic        launch_reg;
    op_t         op_reg;
    key_t        key_reg;
    logic        accept;
    logic        cfg_write;
    carry_t      chain [NUM_SLOTS+1];
    carry_t      last;
    commit_t     commit;
    logic [NUM_SLOTS-1:0] live_vec;

    assign accept = start && !busy_reg;

    // Configuration register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_SLOTS_IN_USE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slots_reg <= SLOTS_IN_USE_RESET;
        end
        else if (cfg_write)
        begin
            slots_reg <= pwdata[3:0];
        end
    end

    assign prdata = (paddr[2] == REG_SLOTS_IN_USE) ? {28'd0, slots_reg} : 32'd0;

    // Busy from accept until the wave leaves the last cell
    always_comb
    begin
        busy_next = busy_reg;
        if (accept)
        begin
            busy_next = 1'b1;
        end
        else if (last.live)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            launch_reg <= 1'b0;
        end
        else
        begin
            busy_reg   <= busy_next;
            launch_reg <= accept;
        end
    end

    // Held request key and operation
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg             <= req_word.op;
            key_reg.request_id <= req_word.request_id;
            key_reg.remote_id  <= req_word.remote_id;
            key_reg.group_num  <= req_word.group_num;
        end
    end

    assign busy = busy_reg;

    // Chain of slot cells
    assign chain[0] = '{live: launch_reg, hit: 1'b0, hit_idx: 3'd0,
                        free: 1'b0, free_idx: 3'd0};

    for (genvar i = 0; i < NUM_SLOTS; i++)
    begin : g_cell
        rsl_slot_cell #(
            .SLOT_NUM (i)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .slots_in_use (slots_reg),
            .key          (key_reg),
            .carry_in     (chain[i]),
            .commit       (commit),
            .carry_out    (chain[i+1])
        );
        assign live_vec[i] = chain[i+1].live;
    end

    assign last = chain[NUM_SLOTS];

    // Decision at the end of the chain
    always_comb
    begin
        commit              = '0;
        rsp_word.slot_index = 3'd0;
        rsp_word.status     = ST_FULL;
        unique case (op_reg)
            OP_LOOKUP:
            begin
                if (last.hit)
                begin
                    rsp_word.slot_index = last.hit_idx;
                    rsp_word.status     = ST_HIT;
                end
                else if (last.free)
                begin
                    rsp_word.slot_index = last.free_idx;
                    rsp_word.status     = ST_ALLOC;
                    commit.alloc        = last.live;
                end
                else
                begin
                    rsp_word.status = ST_FULL;
                end
            end
            OP_RELEASE:
            begin
                if (last.hit)
                begin
                    rsp_word.slot_index = last.hit_idx;
                    rsp_word.status     = ST_RELEASED;
                    commit.release_slot = last.live;
                end
                else
                begin
                    rsp_word.status = ST_REL_MISS;
                end
            end
            default:
            begin
                rsp_word.status = ST_REL_MISS;
            end
        endcase
    end

    assign done = last.live;

    // Checks
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy_reg)
        else $error("done outside a busy window");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (busy_reg && launch_reg))
        else $error("accepted word did not launch a search");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy_reg)
        else $error("busy held after done");

    a_one_wave: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(live_vec))
        else $error("more than one search wave in the chain");

endmodule
`default_nettype wire

// File: tb/sv/tb_request_slot_table.sv
// Self-checking testbench for request_slot_table: lookup, allocate and release traffic.
`timescale 1ns / 1ps
module tb_request_slot_table;
    import rsl_pkg::*;

    localparam int DEPTH      = NUM_SLOTS_DEF;
    localparam int POOL_SIZE  = 12;
    localparam int SEGMENTS   = 12;
    localparam int SEG_WORDS  = 65;
    localparam int CYCLE_LIMIT = 200000;

    // Tracks the slot table and holds the responses still owed by the block
    class slot_table_tracker;
        logic [3:0] slot_count;
        bit         valid [DEPTH];
        key_t       keys [DEPTH];
        rsp_word_t  pending_rsp[$];
        int         errors;
        int         words_in;
        int         tally [8];

        function new();
            slot_count = SLOTS_IN_USE_RESET;
            foreach (valid[i]) valid[i] = 1'b0;
            errors   = 0;
            words_in = 0;
            foreach (tally[i]) tally[i] = 0;
        endfunction

        function void set_count(logic [3:0] v);
            slot_count = v;
        endfunction

        // Apply one accepted request and queue the response it owes
        function void note_request(req_word_t w);
            key_t      k;
            int        n;
            int        hit;
            int        free_slot;
            rsp_word_t e;
            k = '{request_id: w.request_id, remote_id: w.remote_id, group_num: w.group_num};
            n = (int'(slot_count) > DEPTH) ? DEPTH : int'(slot_count);
            hit = -1;
            free_slot = -1;
            for (int i = 0; i < n; i++) begin
                if (hit < 0 && valid[i] && keys[i] == k)
                    hit = i;
                if (free_slot < 0 && !valid[i])
                    free_slot = i;
            end
            e.slot_index = '0;
            if (w.op == OP_LOOKUP) begin
                if (hit >= 0) begin
                    e.slot_index = 3'(hit);
                    e.status     = ST_HIT;
                end else if (free_slot >= 0) begin
                    valid[free_slot] = 1'b1;
                    keys[free_slot]  = k;
                    e.slot_index     = 3'(free_slot);
                    e.status         = ST_ALLOC;
                end else begin
                    e.status = ST_FULL;
                end
            end else begin
                if (hit >= 0) begin
                    valid[hit]   = 1'b0;
                    e.slot_index = 3'(hit);
                    e.status     = ST_RELEASED;
                end else begin
                    e.status = ST_REL_MISS;
                end
            end
            tally[int'(e.status)]++;
            words_in++;
            pending_rsp.push_back(e);
        endfunction

        // Compare one response word with the oldest one owed
        function void check_response(rsp_word_t r);
            rsp_word_t e;
            if (pending_rsp.size() == 0) begin
                $display("%0t: response with none owed: actual index %0d status %0d",
                         $time, r.slot_index, r.status);
                errors++;
                return;
            end
            e = pending_rsp.pop_front();
            if (r.slot_index !== e.slot_index) begin
                $display("%0t: slot_index expected %0d actual %0d",
                         $time, e.slot_index, r.slot_index);
                errors++;
            end
            if (r.status !== e.status) begin
                $display("%0t: status expected %0d actual %0d", $time, e.status, r.status);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    req_word_t   req_word = '0;
    logic        busy;
    logic        done;
    rsp_word_t   rsp_word;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    slot_table_tracker tracker;
    key_t              key_pool [POOL_SIZE];
    bit                count_seen [16];
    int                cycles = 0;

    request_slot_table i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_word (req_word),
        .busy     (busy),
        .done     (done),
        .rsp_word (rsp_word),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 clk = ~clk;

    // Response monitor
    always @(posedge clk)
    begin
        if (rst_n && done)
            tracker.check_response(rsp_word);
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("request_slot_table: mismatch");
            $finish;
        end
    end

    function automatic key_t random_key();
        key_t k;
        k.request_id = 7'($urandom);
        k.remote_id  = 28'($urandom);
        k.group_num  = 4'($urandom);
        return k;
    endfunction

    function automatic req_word_t make_word(op_t op, key_t k);
        req_word_t w;
        w.op         = op;
        w.request_id = k.request_id;
        w.remote_id  = k.remote_id;
        w.group_num  = k.group_num;
        return w;
    endfunction

    // Hold start until the block takes the word
    task automatic send_word(req_word_t w);
        start    <= 1'b1;
        req_word <= w;
        do @(posedge clk); while (busy);
        tracker.note_request(w);
    endtask

    // Random sender gap: with probability pct, start drops and the sender idles
    task automatic sender_gap(int pct);
        if ($urandom_range(99) < pct) begin
            start <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < pct);
        end
    endtask

    // Stop sending and wait until every owed response is back and the block is idle
    task automatic drain();
        start <= 1'b0;
        while (tracker.pending_rsp.size() != 0 || busy)
            @(posedge clk);
    endtask

    // Write slots_in_use, then read it back in the next transfer
    task automatic write_slot_count(logic [3:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_SLOTS_IN_USE, 2'b00};
        pwdata  <= 32'(v);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        tracker.set_count(v);
        count_seen[v] = 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== 32'(v)) begin
            $display("%0t: slots_in_use readback expected %0d actual %0d", $time, v, prdata);
            tracker.errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Short directed run: extremes, full table, release miss, count edge values
    task automatic directed_run();
        key_t zeros;
        key_t ones;
        key_t near;
        key_t dk [6];
        zeros = '0;
        ones  = '1;
        near  = ones;
        near.group_num = 4'he;
        foreach (dk[i]) dk[i] = random_key();
        write_slot_count(4'd8);
        send_word(make_word(OP_LOOKUP, zeros));
        send_word(make_word(OP_LOOKUP, ones));
        send_word(make_word(OP_LOOKUP, zeros));
        send_word(make_word(OP_LOOKUP, near));
        foreach (dk[i]) send_word(make_word(OP_LOOKUP, dk[i]));
        // table full, then a release, a release miss and reuse of the freed slot
        send_word(make_word(OP_LOOKUP, random_key()));
        send_word(make_word(OP_RELEASE, ones));
        send_word(make_word(OP_RELEASE, ones));
        send_word(make_word(OP_LOOKUP, random_key()));
        send_word(make_word(OP_RELEASE, zeros));
        // lowered count hides the upper slots
        drain();
        write_slot_count(4'd2);
        send_word(make_word(OP_LOOKUP, dk[4]));
        send_word(make_word(OP_LOOKUP, dk[5]));
        // zero count: nothing active
        drain();
        write_slot_count(4'd0);
        send_word(make_word(OP_LOOKUP, dk[0]));
        send_word(make_word(OP_RELEASE, dk[0]));
        // count above the table acts as the full table
        drain();
        write_slot_count(4'd15);
        send_word(make_word(OP_RELEASE, dk[4]));
        send_word(make_word(OP_LOOKUP, dk[4]));
        send_word(make_word(OP_LOOKUP, dk[5]));
        drain();
        write_slot_count(4'd1);
        send_word(make_word(OP_LOOKUP, dk[1]));
        send_word(make_word(OP_RELEASE, ones));
        drain();
    endtask

    // Random word: mostly pool keys so hits and releases land, some near misses and noise
    function automatic req_word_t random_word();
        key_t k;
        int   r;
        op_t  op;
        r = $urandom_range(99);
        k = key_pool[$urandom_range(POOL_SIZE - 1)];
        if (r >= 70 && r < 84)
            k[$urandom_range($bits(key_t) - 1)] ^= 1'b1;
        else if (r >= 84)
            k = random_key();
        op = ($urandom_range(99) < 55) ? OP_LOOKUP : OP_RELEASE;
        return make_word(op, k);
    endfunction

    initial
    begin
        logic [3:0] seg_count [SEGMENTS];
        int         idle_pct;
        tracker = new();
        seg_count = '{4'd8, 4'd1, 4'd4, 4'd15, 4'd2, 4'd8, 4'd0, 4'd6, 4'd9, 4'd3, 4'd8, 4'd5};
        foreach (key_pool[i]) key_pool[i] = random_key();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_run();

        // Random segments, each with a slot count from seg_count and an idle rate set per group of four
        for (int s = 0; s < SEGMENTS; s++) begin
            idle_pct = (s < 4) ? 24 : (s < 8) ? 58 : 0;
            for (int j = 0; j < 4; j++)
                key_pool[$urandom_range(POOL_SIZE - 1)] = random_key();
            drain();
            write_slot_count(seg_count[s]);
            for (int n = 0; n < SEG_WORDS; n++) begin
                if ($urandom_range(39) == 0)
                    drain();
                else
                    sender_gap(idle_pct);
                send_word(random_word());
            end
        end

        drain();
        repeat (DEPTH + 4) @(posedge clk);

        $display("checked %0d words: %0d hits, %0d allocations, %0d full, %0d released, %0d release misses",
                 tracker.words_in, tracker.tally[ST_HIT], tracker.tally[ST_ALLOC],
                 tracker.tally[ST_FULL], tracker.tally[ST_RELEASED], tracker.tally[ST_REL_MISS]);
        $display("slot counts 0, 1, 8, above 8 and several in between were exercised: %0d/%0d/%0d/%0d",
                 count_seen[0], count_seen[1], count_seen[8], count_seen[15]);
        if (tracker.errors == 0 && tracker.pending_rsp.size() == 0)
            $display("request_slot_table: match");
        else
            $display("request_slot_table: mismatch");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/rsl_pkg.sv
rtl/core/rsl_slot_cell.sv
rtl/core/request_slot_table.sv
tb/sv/tb_request_slot_table.sv
